>>> hw/rtl/qte_pkg.sv
package qte_pkg;

  localparam int ANGLE_FRAC_BITS   = 7;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int INT_FRAC          = 20;
  localparam int RND_SHIFT         = INT_FRAC - ANGLE_FRAC_BITS;

  localparam int TERM_W  = 34;
  localparam int VEC_W   = 38;
  localparam int ANG_W   = 30;
  localparam int ITER_W  = 5;
  localparam int ITER_N  = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;

  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * (1 << INT_FRAC));
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * (1 << INT_FRAC));
  localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(1 << 30);
  localparam logic signed [14:0] PITCH_LIM = 15'(90 * (1 << ANGLE_FRAC_BITS));

  localparam logic CFG_YAW_OFFSET    = 1'b0;
  localparam logic CFG_OFFSET_ENABLE = 1'b1;

  typedef struct packed {
    logic signed [TERM_W-1:0] sinr;
    logic signed [TERM_W-1:0] cosr;
    logic signed [TERM_W-1:0] sinp;
    logic signed [TERM_W-1:0] siny;
    logic signed [TERM_W-1:0] cosy;
    logic                     clamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic step;
    logic [ITER_W-1:0] iter;
  } lane_ctl_t;

  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [ITER_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANG_W-1:0] to_out(input logic signed [ANG_W-1:0] ang,
                                                     input logic signed [ANG_W-1:0] lim);
    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W:0]   r;
    a = ang;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    r = (ANG_W+1)'(a) + (ANG_W+1)'(1 << (RND_SHIFT - 1));
    r = r >>> RND_SHIFT;
    return r[ANG_W-1:0];
  endfunction

endpackage

>>> hw/rtl/qte_if.sv
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic signed [17:0] yaw_deg;
  logic               pitch_clamped;
  modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, output ready);
endinterface

>>> hw/rtl/qte_front.sv
module qte_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  qte_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output qte_pkg::entry_t entry_o
);

  logic                s_v_q;
  logic signed [31:0]  wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  logic                acc;

  assign in_i.ready = !s_v_q || !full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign push_o     = s_v_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      wx_q <= in_i.quat_w * in_i.quat_x;
      yz_q <= in_i.quat_y * in_i.quat_z;
      xx_q <= in_i.quat_x * in_i.quat_x;
      yy_q <= in_i.quat_y * in_i.quat_y;
      wy_q <= in_i.quat_w * in_i.quat_y;
      zx_q <= in_i.quat_z * in_i.quat_x;
      wz_q <= in_i.quat_w * in_i.quat_z;
      xy_q <= in_i.quat_x * in_i.quat_y;
      zz_q <= in_i.quat_z * in_i.quat_z;
    end
  end

  logic signed [qte_pkg::TERM_W-1:0] sinp;

  always_comb begin
    entry_o.sinr = (qte_pkg::TERM_W'(wx_q) + qte_pkg::TERM_W'(yz_q)) <<< 1;
    entry_o.cosr = qte_pkg::ONE_Q30 -
                   ((qte_pkg::TERM_W'(xx_q) + qte_pkg::TERM_W'(yy_q)) <<< 1);
    sinp         = (qte_pkg::TERM_W'(wy_q) - qte_pkg::TERM_W'(zx_q)) <<< 1;
    entry_o.sinp = sinp;
    entry_o.siny = (qte_pkg::TERM_W'(wz_q) + qte_pkg::TERM_W'(xy_q)) <<< 1;
    entry_o.cosy = qte_pkg::ONE_Q30 -
                   ((qte_pkg::TERM_W'(yy_q) + qte_pkg::TERM_W'(zz_q)) <<< 1);
    entry_o.clamp = (sinp >= qte_pkg::ONE_Q30) || (sinp <= -qte_pkg::ONE_Q30);
  end

endmodule

>>> hw/rtl/qte_queue.sv
module qte_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qte_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output qte_pkg::entry_t entry_o
);

  qte_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> hw/rtl/qte_cordic.sv
module qte_cordic (
  input  logic                             clk_i,
  input  qte_pkg::lane_ctl_t               ctl_i,
  input  logic signed [qte_pkg::VEC_W-1:0] y_i,
  input  logic signed [qte_pkg::VEC_W-1:0] x_i,
  output logic signed [qte_pkg::ANG_W-1:0] ang_o
);

  logic signed [qte_pkg::VEC_W-1:0] x_q, y_q, dx, dy;
  logic signed [qte_pkg::ANG_W-1:0] ang_q, tab;
  logic                             zero_q;

  assign dx    = y_q >>> ctl_i.iter;
  assign dy    = x_q >>> ctl_i.iter;
  assign tab   = qte_pkg::atan_tab(ctl_i.iter);
  assign ang_o = zero_q ? '0 : ang_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q   <= y_i;
          y_q   <= -x_i;
          ang_q <= qte_pkg::DEG90;
        end else begin
          x_q   <= -y_i;
          y_q   <= x_i;
          ang_q <= -qte_pkg::DEG90;
        end
      end else begin
        x_q   <= x_i;
        y_q   <= y_i;
        ang_q <= '0;
      end
    end else if (ctl_i.step) begin
      if (y_q >= 0) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + tab;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - tab;
      end
    end
  end

endmodule

>>> hw/rtl/qte_back.sv
module qte_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [16:0]     cfg_data_i,
  input  logic            empty_i,
  input  qte_pkg::entry_t entry_i,
  output logic            pop_o,
  qte_out_if.source       out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_REM   = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_ROT   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [qte_pkg::ITER_W-1:0] cnt_q, cnt_d;
  qte_pkg::entry_t           ent_q;
  logic [59:0]               sq_q;
  logic [60:0]               rem_q;
  logic [61:0]               res_q;
  logic signed [16:0]        off_q;
  logic                      en_q;
  logic                      out_v_q;
  logic                      out_free;
  qte_pkg::lane_ctl_t        ctl;

  logic [qte_pkg::TERM_W-1:0]       sabs;
  logic [61:0]                      bitv, trial;
  logic signed [qte_pkg::ANG_W-1:0] ang_r, ang_p, ang_y;
  logic signed [qte_pkg::ANG_W-1:0] rr, rp, ry;
  logic signed [qte_pkg::VEC_W-1:0] px;

  assign out_free    = !out_v_q || out_o.ready;
  assign out_o.valid = out_v_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;

  assign sabs  = ent_q.sinp[qte_pkg::TERM_W-1] ? -ent_q.sinp : ent_q.sinp;
  assign bitv  = 62'(1) << {cnt_q, 1'b0};
  assign trial = res_q + bitv;
  assign px    = {{(qte_pkg::VEC_W-31){1'b0}}, res_q[30:0]};

  assign ctl.start = state_q == ST_START;
  assign ctl.step  = state_q == ST_ROT;
  assign ctl.iter  = cnt_q;

  qte_cordic u_roll (.clk_i, .ctl_i(ctl),
    .y_i(qte_pkg::VEC_W'(ent_q.sinr)), .x_i(qte_pkg::VEC_W'(ent_q.cosr)), .ang_o(ang_r));
  qte_cordic u_pitch (.clk_i, .ctl_i(ctl),
    .y_i(qte_pkg::VEC_W'(ent_q.sinp)), .x_i(px), .ang_o(ang_p));
  qte_cordic u_yaw (.clk_i, .ctl_i(ctl),
    .y_i(qte_pkg::VEC_W'(ent_q.siny)), .x_i(qte_pkg::VEC_W'(ent_q.cosy)), .ang_o(ang_y));

  assign rr = qte_pkg::to_out(ang_r, qte_pkg::DEG180);
  assign rp = qte_pkg::to_out(ang_p, qte_pkg::DEG90);
  assign ry = qte_pkg::to_out(ang_y, qte_pkg::DEG180);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE:  if (!empty_i) state_d = ST_SQR;
      ST_SQR:   state_d = ent_q.clamp ? ST_START : ST_REM;
      ST_REM: begin
        state_d = ST_ROOT;
        cnt_d   = 5'd30;
      end
      ST_ROOT: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_ROT;
        cnt_d   = '0;
      end
      ST_ROT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == qte_pkg::ITER_W'(qte_pkg::ITER_N - 1)) state_d = ST_OUT;
      end
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
      off_q   <= '0;
      en_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_OUT && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          qte_pkg::CFG_YAW_OFFSET:    off_q <= cfg_data_i;
          qte_pkg::CFG_OFFSET_ENABLE: en_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= entry_i;
    if (state_q == ST_SQR) sq_q <= sabs[29:0] * sabs[29:0];
    if (state_q == ST_REM) begin
      rem_q <= (61'(1) << 60) - 61'(sq_q);
      res_q <= '0;
    end
    if (state_q == ST_ROOT) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q <= rem_q - trial[60:0];
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (state_q == ST_OUT && out_free) begin
      out_o.roll_deg      <= rr[15:0];
      out_o.pitch_deg     <= ent_q.clamp ?
                             (ent_q.sinp[qte_pkg::TERM_W-1] ? -qte_pkg::PITCH_LIM
                                                            : qte_pkg::PITCH_LIM) : rp[14:0];
      out_o.yaw_deg       <= ry[17:0] + (en_q ? 18'(off_q) : 18'sd0);
      out_o.pitch_clamped <= ent_q.clamp;
    end
  end

endmodule

>>> hw/rtl/quaternion_to_euler_yaw_offset.sv
// Quaternion (w, x, y, z, signed Q1.15) to ZYX Euler angles in degrees, 7 fraction bits.
// in_i takes one quaternion request per valid/ready handshake; out_o returns one result
// request (roll, pitch, yaw, pitch_clamped) for each, in order.
// The front multiplies the nine product terms and forms the atan2 arguments; a two-entry
// queue sits between it and the back, so requests keep arriving while the back works.
// The back runs one request at a time: first the square of the pitch sine, then a
// 31-step restoring square root (one step a cycle, skipped when pitch is clamped), then
// three CORDIC lanes in parallel for 16 iterations, then the output register.
// Sustained throughput is set by the square root and CORDIC iteration loop of the back,
// which pops the next request only after the previous result enters the output register.
// cfg_we_i writes yaw_offset (index 0) or offset_enable (index 1); write only while idle.
// Reset clears the queue, the back state, the output valid and both registers.
// When the receiver stalls the result holds in the output register, the back waits and
// the queue then the front fill before in_i.ready drops.
module quaternion_to_euler_yaw_offset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  qte_in_if.sink      in_i,
  qte_out_if.source   out_o
);

  logic            push, full, pop, empty;
  qte_pkg::entry_t f_ent, q_ent;

  qte_front u_front (.clk_i, .rst_ni, .in_i, .full_i(full), .push_o(push), .entry_o(f_ent));

  qte_queue u_queue (.clk_i, .rst_ni, .push_i(push), .entry_i(f_ent), .full_o(full),
    .pop_i(pop), .empty_o(empty), .entry_o(q_ent));

  qte_back u_back (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .empty_i(empty), .entry_i(q_ent), .pop_o(pop), .out_o);

endmodule

>>> tb/tb_quaternion_to_euler_yaw_offset.sv
module tb_quaternion_to_euler_yaw_offset;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PHASE_ITEMS    = 170;
  localparam int NUM_PHASES     = 8;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [17:0] yaw;
    logic               clamped;
  } euler_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;
    logic signed [14:0] pitch;
    logic               clamped;
  } quat_row_t;

  localparam longint ARC_TAB [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };
  localparam longint Q30    = longint'(1) << 30;
  localparam longint ANG90  = longint'(90) << 20;
  localparam longint ANG180 = longint'(180) << 20;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [16:0] cfg_data_i;

  qte_in_if  in_i ();
  qte_out_if out_o ();

  quaternion_to_euler_yaw_offset dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i.sink),
    .out_o      (out_o.source)
  );

  logic signed [16:0] yaw_ofs_q;
  logic               ofs_en_q;
  euler_t             pending_angles [$];
  int                 errors;
  bit                 quiet;
  int                 idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint vec_atan2(longint yy, longint xx);
    longint ang, t, dx, dy;
    ang = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      if (yy >= 0) begin
        t = xx; xx = yy; yy = -t; ang = ANG90;
      end else begin
        t = xx; xx = -yy; yy = t; ang = -ANG90;
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
      dx = yy >>> i;
      dy = xx >>> i;
      if (yy >= 0) begin
        xx += dx; yy -= dy; ang += ARC_TAB[i];
      end else begin
        xx -= dx; yy += dy; ang -= ARC_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_angle(longint ang, longint lim);
    if (ang > lim) ang = lim;
    if (ang < -lim) ang = -lim;
    return (ang + (longint'(1) << (qte_pkg::RND_SHIFT - 1))) >>> qte_pkg::RND_SHIFT;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                            logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, sinr, cosr, sinp, siny, cosy, p, yw;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    sinr = 2 * (w * x + y * z);
    cosr = Q30 - 2 * (x * x + y * y);
    sinp = 2 * (w * y - z * x);
    siny = 2 * (w * z + x * y);
    cosy = Q30 - 2 * (y * y + z * z);
    e.roll = 16'(round_angle(vec_atan2(sinr, cosr), ANG180));
    if (sinp >= Q30 || sinp <= -Q30) begin
      p = longint'(90) << qte_pkg::ANGLE_FRAC_BITS;
      if (sinp < 0) p = -p;
      e.clamped = 1'b1;
    end else begin
      p = round_angle(vec_atan2(sinp, floor_sqrt((longint'(1) << 60) - sinp * sinp)), ANG90);
      e.clamped = 1'b0;
    end
    e.pitch = 15'(p);
    yw = round_angle(vec_atan2(siny, cosy), ANG180);
    if (ofs_en_q) yw += longint'(yaw_ofs_q);
    e.yaw = 18'(yw);
    return e;
  endfunction

  task automatic write_reg(logic idx, logic [16:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == qte_pkg::CFG_YAW_OFFSET) yaw_ofs_q = data;
    else ofs_en_q = data[0];
    @(posedge clk_i);
  endtask

  task automatic wait_all_done();
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_quat(quat_row_t r);
    euler_t e;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_i.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_i.valid  <= 1'b1;
    in_i.quat_w <= r.w;
    in_i.quat_x <= r.x;
    in_i.quat_y <= r.y;
    in_i.quat_z <= r.z;
    do @(posedge clk_i); while (!in_i.ready);
    e = predict_angles(r.w, r.x, r.y, r.z);
    if (r.typed) begin
      e.pitch   = r.pitch;
      e.clamped = r.clamped;
    end
    pending_angles = {pending_angles, e};
  endtask

  function automatic quat_row_t random_quat();
    quat_row_t r;
    real v [4];
    real n;
    int mode, a;
    r.typed = 0; r.pitch = '0; r.clamped = 1'b0;
    mode = $urandom_range(0, 9);
    if (mode <= 1) begin
      r.w = 16'($urandom); r.x = 16'($urandom); r.y = 16'($urandom); r.z = 16'($urandom);
    end else if (mode == 2) begin
      // hover around the pitch singularity
      a = $urandom_range(22900, 23400);
      r.w = 16'(a);
      r.y = $urandom_range(0, 1) ? 16'(a) : -16'(a);
      r.x = 16'(int'($urandom_range(0, 600)) - 300);
      r.z = $urandom_range(0, 1) ? r.x : -r.x;
    end else if (mode == 3) begin
      r.w = 16'(int'($urandom_range(0, 8)) - 4);
      r.x = 16'(int'($urandom_range(0, 8)) - 4);
      r.y = 16'(int'($urandom_range(0, 8)) - 4);
      r.z = 16'(int'($urandom_range(0, 8)) - 4);
    end else begin
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
        v[i] = real'(int'($urandom_range(0, 65535)) - 32768);
        n += v[i] * v[i];
      end
      n = $sqrt(n);
      if (n < 1.0) begin
        v[0] = 1.0; n = 1.0 / 32767.0;
      end
      r.w = 16'($rtoi(v[0] * 32767.0 / n));
      r.x = 16'($rtoi(v[1] * 32767.0 / n));
      r.y = 16'($rtoi(v[2] * 32767.0 / n));
      r.z = 16'($rtoi(v[3] * 32767.0 / n));
    end
    return r;
  endfunction

  quat_row_t directed [] = '{
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 0, 15'sd0, 1'b0},
    '{16'sd23171, 16'sd0, 16'sd23171, 16'sd0, 1, 15'sd11520, 1'b1},
    '{16'sd23171, 16'sd0, -16'sd23171, 16'sd0, 1, -15'sd11520, 1'b1},
    '{16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 1, 15'sd11520, 1'b1},
    '{-16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1, 15'sd11520, 1'b1},
    '{16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 0, 15'sd0, 1'b0},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, 15'sd0, 1'b0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, 15'sd0, 1'b0},
    '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 0, 15'sd0, 1'b0},
    '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd23170, -16'sd23170, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0},
    '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 0, 15'sd0, 1'b0},
    '{16'sd23170, 16'sd0, 16'sd0, -16'sd23170, 0, 15'sd0, 1'b0},
    '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 0, 15'sd0, 1'b0}
  };

  initial begin
    logic signed [16:0] ofs;
    logic en;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= qte_pkg::CFG_YAW_OFFSET;
    cfg_data_i  <= '0;
    in_i.valid  <= 1'b0;
    in_i.quat_w <= '0;
    in_i.quat_x <= '0;
    in_i.quat_y <= '0;
    in_i.quat_z <= '0;
    yaw_ofs_q = '0;
    ofs_en_q  = 1'b0;
    errors = 0;
    quiet  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_quat(directed[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_i.valid <= 1'b0;
      wait_all_done();
      case (ph)
        0: begin ofs = -17'sd46080; en = 1'b1; end
        1: begin ofs = 17'sd46080; en = 1'b1; end
        2: begin ofs = 17'sd46080; en = 1'b0; end
        default: begin
          ofs = 17'(int'($urandom_range(0, 92160)) - 46080);
          en  = (ph == NUM_PHASES - 1) ? 1'b1 : 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(qte_pkg::CFG_YAW_OFFSET, ofs);
      write_reg(qte_pkg::CFG_OFFSET_ENABLE, {16'd0, en});
      cfg_we_i <= 1'b0;
      if (ph == NUM_PHASES - 1) quiet = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) begin
          // hold off until the pipeline is empty
          in_i.valid <= 1'b0;
          do @(posedge clk_i); while (pending_angles.size() != 0);
        end
        send_quat(random_quat());
      end
    end
    in_i.valid <= 1'b0;
    wait_all_done();
    if (errors == 0) $display("** quaternion_to_euler_yaw_offset: PASSED **");
    else $display("** quaternion_to_euler_yaw_offset: FAILED **");
    $finish;
  end

  initial begin
    out_o.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_o.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_o.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    euler_t e;
    if (out_o.valid && out_o.ready) begin
      if (pending_angles.size() == 0) begin
        errors++;
        $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d clamped=%0b", $time,
                 out_o.roll_deg, out_o.pitch_deg, out_o.yaw_deg, out_o.pitch_clamped);
      end else begin
        e = pending_angles.pop_front();
        if (out_o.roll_deg !== e.roll) begin
          errors++;
          $display("%0t: roll_deg expected %0d actual %0d", $time, e.roll, out_o.roll_deg);
        end
        if (out_o.pitch_deg !== e.pitch) begin
          errors++;
          $display("%0t: pitch_deg expected %0d actual %0d", $time, e.pitch, out_o.pitch_deg);
        end
        if (out_o.yaw_deg !== e.yaw) begin
          errors++;
          $display("%0t: yaw_deg expected %0d actual %0d", $time, e.yaw, out_o.yaw_deg);
        end
        if (out_o.pitch_clamped !== e.clamped) begin
          errors++;
          $display("%0t: pitch_clamped expected %0b actual %0b", $time, e.clamped,
                   out_o.pitch_clamped);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** quaternion_to_euler_yaw_offset: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> quaternion_to_euler_yaw_offset.f
hw/rtl/qte_pkg.sv
hw/rtl/qte_if.sv
hw/rtl/qte_front.sv
hw/rtl/qte_queue.sv
hw/rtl/qte_cordic.sv
hw/rtl/qte_back.sv
hw/rtl/quaternion_to_euler_yaw_offset.sv
tb/tb_quaternion_to_euler_yaw_offset.sv
